/* rtl/acd_pkg.sv */
// Shared types, constants and AES helper functions for the AES-128 CTR byte decryptor.
// No dependencies; acd_front, acd_aes, acd_back and the top level import this package.
package acd_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int MID_DEPTH       = 2;
	localparam int OUT_DEPTH       = 2;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 64;
	localparam int AES_ROUNDS      = 10;
	localparam int BLOCK_BYTES     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

	localparam logic [7:0] RCON_FIRST = 8'h01;

	typedef enum logic {
		JOB_PREFETCH,
		JOB_RESTART
	} job_kind_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        is_encrypted;
		logic        restart;
		logic [63:0] iv_high;
		logic [63:0] iv_low;
		logic [31:0] start_offset;
		logic        region_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic       region_last;
	} out_item_t;

	// Classified request as it waits between front and back.
	typedef struct packed {
		logic [7:0]   data_byte;
		logic         enc;
		logic         restart;
		logic [127:0] ctr;
		logic [3:0]   pos;
		logic         region_end;
	} work_t;

	typedef struct packed {
		logic         start;
		logic         abort;
		logic [127:0] block;
	} aes_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} aes_stat_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a 128-bit block, byte 0 in the top bits.
	function automatic logic [7:0] get_byte(input logic [127:0] blk, input logic [3:0] i);
		return blk[8*(15-i) +: 8];
	endfunction

	// One step of the AES-128 key schedule.
	function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rcon);
		logic [31:0] w0, w1, w2, w3, tmp, n0, n1, n2, n3;
		{w0, w1, w2, w3} = rk;
		tmp = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		n0 = w0 ^ tmp;
		n1 = w1 ^ n0;
		n2 = w2 ^ n1;
		n3 = w3 ^ n2;
		return {n0, n1, n2, n3};
	endfunction

	// SubBytes, ShiftRows and, except in the last round, MixColumns.
	function automatic logic [127:0] enc_round(input logic [127:0] st, input logic last);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] res;
		for (int i = 0; i < 16; i++) s[i] = st[8*(15-i) +: 8];
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[c*4+i] = SBOX[s[((c+i)&3)*4+i]];
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[c*4];
				a1 = t[c*4+1];
				a2 = t[c*4+2];
				a3 = t[c*4+3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[c*4]   = a0 ^ all ^ xtime(a0 ^ a1);
				t[c*4+1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[c*4+2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[c*4+3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) res[8*(15-i) +: 8] = t[i];
		return res;
	endfunction

endpackage

/* rtl/acd_fifo.sv */
// Small synchronous queue used between front and back and in front of the result port.
// Depends on nothing; DEPTH must be a power of two, at least 2.
module acd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push_ok, pop_ok;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) wr_q <= wr_q + 1'b1;
			if (pop_ok) rd_q <= rd_q + 1'b1;
			if (push_ok && !pop_ok) cnt_q <= cnt_q + 1'b1;
			else if (pop_ok && !push_ok) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) mem_q[wr_q] <= wdata;
	end
endmodule

/* rtl/acd_front.sv */
// Front end: takes input requests, applies a restart's offset to the IV and
// hands a classified request to the middle queue. Depends on acd_pkg.
module acd_front #(
	parameter int OFFSET_BITS = acd_pkg::OFFSET_BITS_DEF
) (
	input  logic             push,
	input  acd_pkg::in_item_t item,
	input  logic             mid_full,
	output logic             full,
	output logic             mid_push,
	output acd_pkg::work_t   mid_item
);
	import acd_pkg::*;

	// Offset bits at or above OFFSET_BITS are ignored.
	localparam logic [31:0] OFF_MASK =
		(OFFSET_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << OFFSET_BITS) - 64'd1);

	logic [31:0] off;

	assign off      = item.start_offset & OFF_MASK;
	assign full     = mid_full;
	assign mid_push = push && !mid_full;

	always_comb begin
		mid_item            = '0;
		mid_item.data_byte  = item.data_byte;
		mid_item.enc        = item.is_encrypted;
		mid_item.restart    = item.restart;
		mid_item.region_end = item.region_end;
		mid_item.pos        = off[3:0];
		mid_item.ctr        = {item.iv_high, item.iv_low} + {100'd0, off[31:4]};
	end
endmodule

/* rtl/acd_aes.sv */
// Iterative AES-128 encryption unit: one round and one key-schedule step per cycle.
// Depends on acd_pkg for the S-box and round functions.
module acd_aes (
	input  logic              clk,
	input  logic              arst_n,
	input  acd_pkg::aes_cmd_t cmd,
	input  logic [127:0]      key,
	output acd_pkg::aes_stat_t st,
	output logic [127:0]      result
);
	import acd_pkg::*;

	logic [127:0] s_q, rk_q, rk_n, s_n;
	logic [7:0]   rcon_q;
	logic [3:0]   round_q;
	logic         busy_q, done_q;
	logic         last;

	assign last    = (round_q == 4'(AES_ROUNDS));
	assign rk_n    = key_step(rk_q, rcon_q);
	assign s_n     = enc_round(s_q, last) ^ rk_n;
	assign st.busy = busy_q;
	assign st.done = done_q;
	assign result  = s_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			round_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.abort) begin
				busy_q <= 1'b0;
			end else if (cmd.start) begin
				busy_q  <= 1'b1;
				round_q <= 4'd1;
			end else if (busy_q) begin
				round_q <= round_q + 4'd1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			s_q    <= cmd.block ^ key;
			rk_q   <= key;
			rcon_q <= RCON_FIRST;
		end else if (busy_q) begin
			s_q    <= s_n;
			rk_q   <= rk_n;
			rcon_q <= xtime(rcon_q);
		end
	end
endmodule

/* rtl/acd_back.sv */
// Back end: holds counter, keystream and block position, steers the AES unit
// for restarts and next-block prefetch, and emits result bytes. Depends on acd_pkg.
module acd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               flush,
	input  acd_pkg::work_t     head,
	input  logic               mid_empty,
	output logic               mid_pop,
	input  logic               out_full,
	output logic               out_push,
	output acd_pkg::out_item_t out_item,
	output acd_pkg::aes_cmd_t  aes_cmd,
	input  acd_pkg::aes_stat_t aes_st,
	input  logic [127:0]       aes_result
);
	import acd_pkg::*;

	logic [127:0] ctr_q, ks_q, pf_ks_q, rs_ks_q;
	logic [4:0]   pos_q;
	logic         pf_valid_q, rs_ready_q;
	job_kind_t    kind_q;

	logic [127:0] ctr_inc, ctr_use, ks_use;
	logic [3:0]   p;
	logic [4:0]   pos_next;
	logic         hv, consume, start_rs, start_pf, rs_running;

	assign hv         = !mid_empty;
	assign ctr_inc    = ctr_q + 128'd1;
	assign rs_running = (aes_st.busy || aes_st.done) && (kind_q == JOB_RESTART);

	always_comb begin
		consume  = 1'b0;
		ctr_use  = ctr_q;
		ks_use   = ks_q;
		p        = pos_q[3:0];
		pos_next = pos_q;
		if (hv && !out_full) begin
			if (head.restart) begin
				consume = rs_ready_q;
				ctr_use = head.ctr;
				ks_use  = rs_ks_q;
				p       = head.pos;
			end else if (head.enc && pos_q[4]) begin
				// Block used up: switch to the prefetched next block.
				consume = pf_valid_q;
				ctr_use = ctr_inc;
				ks_use  = pf_ks_q;
				p       = '0;
			end else begin
				consume = 1'b1;
			end
		end
		if (head.enc) pos_next = {1'b0, p} + 5'd1;
		else if (head.restart) pos_next = {1'b0, p};

		// The counter only moves on a restart or a block crossing; neither can coincide
		// with a prefetch start, so the prefetch runs while ordinary bytes stream.
		start_rs = !flush && hv && head.restart && !rs_ready_q && !rs_running;
		start_pf = !flush && !pf_valid_q && !aes_st.busy && !aes_st.done && !start_rs
			&& !(hv && head.restart);

		aes_cmd.start = start_rs || start_pf;
		aes_cmd.abort = flush;
		aes_cmd.block = start_rs ? head.ctr : ctr_inc;

		out_item.plain_byte  = head.enc ? (head.data_byte ^ get_byte(ks_use, p))
			: head.data_byte;
		out_item.region_last = head.region_end;
	end

	assign mid_pop  = consume;
	assign out_push = consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q      <= '0;
			ks_q       <= '0;
			pos_q      <= 5'(BLOCK_BYTES);
			pf_valid_q <= 1'b0;
			rs_ready_q <= 1'b0;
			kind_q     <= JOB_PREFETCH;
		end else begin
			if (aes_cmd.start) kind_q <= start_rs ? JOB_RESTART : JOB_PREFETCH;
			if (consume) begin
				ctr_q <= ctr_use;
				ks_q  <= ks_use;
				pos_q <= pos_next;
			end
			if (flush) begin
				pf_valid_q <= 1'b0;
				rs_ready_q <= 1'b0;
			end else begin
				if (consume && (head.restart || (head.enc && pos_q[4]))) pf_valid_q <= 1'b0;
				else if (aes_st.done && kind_q == JOB_PREFETCH) pf_valid_q <= 1'b1;
				if (consume && head.restart) rs_ready_q <= 1'b0;
				else if (aes_st.done && kind_q == JOB_RESTART) rs_ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (aes_st.done && kind_q == JOB_PREFETCH) pf_ks_q <= aes_result;
		if (aes_st.done && kind_q == JOB_RESTART) rs_ks_q <= aes_result;
	end
endmodule

/* rtl/aes_ctr_cenc_byte_decryptor.sv */
// AES-128 counter-mode byte decryptor. One byte request is taken per cycle and one
// result byte leaves per cycle when neither queue side stalls. The AES unit
// precomputes the next counter's keystream in the background, so crossing a 16-byte
// block costs nothing in steady streaming. A restart request waits for the AES of
// its new counter, and an encrypted byte right after a restart or key write may
// likewise wait for the AES of its next block. Requests pass through the middle queue
// and the result queue. Write the key only while the block is idle.
module aes_ctr_cenc_byte_decryptor #(
	parameter int OFFSET_BITS = acd_pkg::OFFSET_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  acd_pkg::in_item_t              item,
	output logic                           empty,
	input  logic                           pop,
	output acd_pkg::out_item_t             result,
	input  logic                           cfg_we,
	input  logic [acd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import acd_pkg::*;

	logic [63:0] key_high_q, key_low_q;
	logic        mid_push, mid_full, mid_empty, mid_pop;
	work_t       mid_in, mid_head;
	logic        out_push, out_full;
	out_item_t   out_in;
	aes_cmd_t    aes_cmd;
	aes_stat_t   aes_st;
	logic [127:0] aes_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	acd_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.push(push), .item(item), .mid_full(mid_full), .full(full),
		.mid_push(mid_push), .mid_item(mid_in)
	);

	acd_fifo #(.WIDTH($bits(work_t)), .DEPTH(MID_DEPTH)) u_mid (
		.clk(clk), .arst_n(arst_n), .push(mid_push), .wdata(mid_in), .full(mid_full),
		.pop(mid_pop), .rdata(mid_head), .empty(mid_empty)
	);

	acd_back u_back (
		.clk(clk), .arst_n(arst_n), .flush(cfg_we), .head(mid_head),
		.mid_empty(mid_empty), .mid_pop(mid_pop), .out_full(out_full),
		.out_push(out_push), .out_item(out_in), .aes_cmd(aes_cmd), .aes_st(aes_st),
		.aes_result(aes_result)
	);

	acd_aes u_aes (
		.clk(clk), .arst_n(arst_n), .cmd(aes_cmd), .key({key_high_q, key_low_q}),
		.st(aes_st), .result(aes_result)
	);

	acd_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_out (
		.clk(clk), .arst_n(arst_n), .push(out_push), .wdata(out_in), .full(out_full),
		.pop(pop), .rdata(result), .empty(empty)
	);

	// A result is only produced when the output queue has room for it.
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full) else $error("result pushed into full output queue");

	// Every consumed request leaves exactly one result.
	a_pop_push: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop == out_push) else $error("request consumed without result");

	// A finished AES job was running the cycle before.
	a_aes_done: assert property (@(posedge clk) disable iff (!arst_n)
		aes_st.done |-> $past(aes_st.busy)) else $error("AES done without a job");

	a_mid_pop: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty) else $error("pop from empty middle queue");
endmodule

/* tb/tb_aes_ctr_cenc_byte_decryptor.sv */
// Self-checking testbench for the AES-128 counter-mode byte decryptor.
// Depends on acd_pkg and the aes_ctr_cenc_byte_decryptor RTL only.
`timescale 1ns / 1ps

module tb_aes_ctr_cenc_byte_decryptor;
	import acd_pkg::*;

	// Holds the key, counter and keystream that the block should have, and the bytes it owes.
	class decrypt_scoreboard;
		logic [63:0]  key_hi, key_lo;
		logic [127:0] ctr;
		logic [127:0] kstream;
		int unsigned  pos;
		out_item_t    owed[$];
		int           errors;
		int           shown;

		function void clear();
			key_hi = '0;
			key_lo = '0;
			ctr = '0;
			kstream = '0;
			pos = 16;
			owed.delete();
			errors = 0;
			shown = 0;
		endfunction

		function void set_key(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
			if (idx == REG_KEY_HIGH)
				key_hi = val;
			else
				key_lo = val;
		endfunction

		function logic [7:0] mul2(logic [7:0] a);
			return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		endfunction

		// Plain AES-128 encryption of the counter under the current key.
		function logic [127:0] encrypt_block(logic [127:0] blk);
			logic [7:0] rk [176];
			logic [7:0] s [16];
			logic [7:0] t [16];
			logic [7:0] w0, w1, w2, w3, tmp, rc, a0, a1, a2, a3, al;
			logic [127:0] res;
			rc = 8'h01;
			for (int i = 0; i < 8; i++) begin
				rk[i] = key_hi[56-8*i +: 8];
				rk[i+8] = key_lo[56-8*i +: 8];
			end
			for (int i = 16; i < 176; i += 4) begin
				w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
				if ((i % 16) == 0) begin
					tmp = w0;
					w0 = SBOX[w1] ^ rc;
					w1 = SBOX[w2];
					w2 = SBOX[w3];
					w3 = SBOX[tmp];
					rc = mul2(rc);
				end
				rk[i] = rk[i-16] ^ w0;
				rk[i+1] = rk[i-15] ^ w1;
				rk[i+2] = rk[i-14] ^ w2;
				rk[i+3] = rk[i-13] ^ w3;
			end
			for (int i = 0; i < 16; i++) s[i] = blk[120-8*i +: 8] ^ rk[i];
			for (int r = 1; r <= 10; r++) begin
				for (int c = 0; c < 4; c++)
					for (int i = 0; i < 4; i++)
						t[c*4+i] = SBOX[s[((c+i)%4)*4+i]];
				if (r != 10) begin
					for (int c = 0; c < 4; c++) begin
						a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
						al = a0 ^ a1 ^ a2 ^ a3;
						t[c*4] = a0 ^ al ^ mul2(a0 ^ a1);
						t[c*4+1] = a1 ^ al ^ mul2(a1 ^ a2);
						t[c*4+2] = a2 ^ al ^ mul2(a2 ^ a3);
						t[c*4+3] = a3 ^ al ^ mul2(a3 ^ a0);
					end
				end
				for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[r*16+i];
			end
			for (int i = 0; i < 16; i++) res[120-8*i +: 8] = s[i];
			return res;
		endfunction

		function void note_request(in_item_t it);
			out_item_t o;
			logic [31:0] off;
			o.plain_byte = it.data_byte;
			o.region_last = it.region_end;
			if (it.restart) begin
				off = it.start_offset;
				ctr = {it.iv_high, it.iv_low} + 128'(off >> 4);
				pos = off % 16;
				kstream = encrypt_block(ctr);
			end
			if (it.is_encrypted) begin
				if (pos >= 16) begin
					ctr = ctr + 128'd1;
					kstream = encrypt_block(ctr);
					pos = 0;
				end
				o.plain_byte = it.data_byte ^ kstream[120-8*pos +: 8];
				pos++;
			end
			owed.push_back(o);
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			if (owed.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected result %h/%b", got.plain_byte, got.region_last);
				end
				return;
			end
			exp = owed.pop_front();
			if (got.plain_byte !== exp.plain_byte || got.region_last !== exp.region_last) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("mismatch: expected byte %h last %b, got byte %h last %b",
						exp.plain_byte, exp.region_last, got.plain_byte, got.region_last);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	in_item_t              item;
	logic                  empty;
	logic                  pop;
	out_item_t             result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	decrypt_scoreboard sb;
	int unsigned cycles;
	bit          pop_busy;
	logic [63:0] iv_hi, iv_lo;

	localparam int unsigned CYCLE_LIMIT = 400000;

	aes_ctr_cenc_byte_decryptor dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		pop = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sb = new();
		sb.clear();
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** aes_ctr_cenc_byte_decryptor: FAILED **");
			$finish;
		end
	end

	// Result side: random stalls, and with some runs of steady popping.
	initial begin
		int unsigned stall;
		cycles = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) sb.check_result(result);
			if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (pop && !empty && $urandom_range(0, 3) == 0) stall = gap_len();
			end
		end
	end

	task automatic send_request(in_item_t it);
		int unsigned g;
		g = gap_len();
		repeat (g) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		sb.note_request(it);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_key(idx, val);
	endtask

	function automatic in_item_t make_byte(bit enc, bit rst, logic [31:0] off);
		in_item_t it;
		it.data_byte = 8'($urandom);
		it.is_encrypted = enc;
		it.restart = rst;
		it.iv_high = {$urandom, $urandom};
		it.iv_low = {$urandom, $urandom};
		it.start_offset = off;
		it.region_end = $urandom_range(0, 7) == 0;
		return it;
	endfunction

	initial begin
		in_item_t it;
		int unsigned len;
		int unsigned rekeys;
		rekeys = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Encrypted bytes with no restart start from counter one under the zero key.
		it = make_byte(1'b1, 1'b0, 32'd0);
		it.data_byte = 8'h00;
		send_request(it);
		it = make_byte(1'b1, 1'b0, 32'd0);
		it.data_byte = 8'hff;
		it.region_end = 1'b1;
		send_request(it);
		wait_drained();

		write_key(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
		write_key(REG_KEY_LOW, 64'habf7158809cf4f3c);

		// Restart on a clear byte still loads the counter.
		it = make_byte(1'b0, 1'b1, 32'd5);
		send_request(it);
		repeat (12) send_request(make_byte(1'b1, 1'b0, 32'd0));
		// Counter wraps past all ones, with the offset at its top value.
		it = make_byte(1'b1, 1'b1, 32'hffffffff);
		it.iv_high = '1;
		it.iv_low = '1;
		send_request(it);
		repeat (3) send_request(make_byte(1'b1, 1'b0, 32'd0));
		it = make_byte(1'b1, 1'b1, 32'd0);
		it.iv_high = '0;
		it.iv_low = '0;
		it.data_byte = 8'hff;
		send_request(it);
		send_request(make_byte(1'b0, 1'b0, 32'd0));
		send_request(make_byte(1'b1, 1'b0, 32'd0));
		wait_drained();

		// The held keystream block survives a key change; later blocks use the new key.
		write_key(REG_KEY_HIGH, '1);
		write_key(REG_KEY_LOW, '1);
		repeat (20) send_request(make_byte(1'b1, 1'b0, 32'd0));
		wait_drained();

		for (int n = 0; n < 500; ) begin
			if ((rekeys == 0 && n >= 180) || (rekeys == 1 && n >= 370)) begin
				wait_drained();
				write_key(REG_KEY_HIGH, rekeys == 0 ? 64'h0 : {$urandom, $urandom});
				write_key(REG_KEY_LOW, {$urandom, $urandom});
				rekeys++;
			end
			iv_hi = $urandom_range(0, 5) == 0 ? '1 : {$urandom, $urandom};
			iv_lo = $urandom_range(0, 3) == 0 ? '1 - 64'($urandom_range(0, 40)) :
				{$urandom, $urandom};
			len = $urandom_range(1, 40);
			for (int k = 0; k < len; k++) begin
				it = make_byte($urandom_range(0, 4) != 0, k == 0 || $urandom_range(0, 30) == 0,
					$urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 70));
				it.iv_high = iv_hi;
				it.iv_low = iv_lo;
				it.region_end = (k == len - 1) || $urandom_range(0, 20) == 0;
				send_request(it);
				n++;
			end
		end
		wait_drained();

		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("** aes_ctr_cenc_byte_decryptor: PASSED **");
		else
			$display("** aes_ctr_cenc_byte_decryptor: FAILED **");
		$finish;
	end
endmodule
